[rtl/pae_pkg.sv]
// Shared types, codes and helpers of the pseudo-assembler execute unit.
`default_nettype none
package pae_pkg;

    localparam int MEM_WORDS_DEF = 256;

    typedef enum logic [1:0] {
        CMD_EXEC    = 2'd0,
        CMD_PRELOAD = 2'd1,
        CMD_READ    = 2'd2
    } t_cmd_code;

    localparam logic [7:0] OP_ADD  = 8'h10;
    localparam logic [7:0] OP_SUB  = 8'h12;
    localparam logic [7:0] OP_MUL  = 8'h14;
    localparam logic [7:0] OP_DIV  = 8'h16;
    localparam logic [7:0] OP_CMP  = 8'h18;
    localparam logic [7:0] OP_ADDM = 8'hD1;
    localparam logic [7:0] OP_SUBM = 8'hD3;
    localparam logic [7:0] OP_MULM = 8'hD5;
    localparam logic [7:0] OP_DIVM = 8'hD7;
    localparam logic [7:0] OP_CMPM = 8'hD9;
    localparam logic [7:0] OP_JMP  = 8'hE0;
    localparam logic [7:0] OP_JZ   = 8'hE1;
    localparam logic [7:0] OP_JP   = 8'hE2;
    localparam logic [7:0] OP_JN   = 8'hE3;
    localparam logic [7:0] OP_MOV  = 8'h31;
    localparam logic [7:0] OP_LD   = 8'hF0;
    localparam logic [7:0] OP_LEA  = 8'hF2;
    localparam logic [7:0] OP_ST   = 8'hF3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DIV0  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam logic [1:0] CC_ZERO = 2'd0;
    localparam logic [1:0] CC_POS  = 2'd1;
    localparam logic [1:0] CC_NEG  = 2'd2;
    localparam logic [1:0] CC_NONE = 2'd3;

    typedef struct packed {
        logic [1:0]         command;
        logic [7:0]         opcode;
        logic [3:0]         dest_reg;
        logic [3:0]         src_reg;
        logic [15:0]        displacement;
        logic [7:0]         word_index;
        logic signed [31:0] word_data;
        logic               word_used;
    } t_in;

    typedef struct packed {
        logic [1:0]         status;
        logic               branch_taken;
        logic [15:0]        branch_target;
        logic [1:0]         condition;
        logic               reg_written;
        logic [3:0]         reg_index;
        logic signed [31:0] reg_value;
        logic               mem_touched;
        logic [7:0]         mem_index;
        logic signed [31:0] read_data;
        logic               read_used;
    } t_out;

    function automatic logic [1:0] cond_of(input logic [31:0] v);
        logic [1:0] c;
        if (v == 32'd0) begin
            c = CC_ZERO;
        end else if (v[31]) begin
            c = CC_NEG;
        end else begin
            c = CC_POS;
        end
        return c;
    endfunction

endpackage
`default_nettype wire

[rtl/pseudo_assembler_execute_unit_core.sv]
// Top level of the pseudo-assembler execute unit: register file, word memory and sequencer.
`default_nettype none
// One word is taken when start is high and busy is low; its result appears on
// o_res with o_done high for a single cycle and cannot be held off. After
// reset the block runs a clearing pass over the word memory and the register
// file, with busy high. A word then passes through a register file read, a
// memory read and an execute into the result register, and busy falls in the
// cycle the result is shown; multiply adds a step for its product register and
// divide waits for the divider, which yields one quotient bit per cycle. Both
// stores are single synchronous memories with registered reads; one word is in
// flight at a time, so every write-back lands before the next word reads.
module pseudo_assembler_execute_unit_core #(
    parameter int MEM_WORDS = pae_pkg::MEM_WORDS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire pae_pkg::t_in  i_cmd,
    output logic               o_done,
    output pae_pkg::t_out      o_res
);
    import pae_pkg::*;

    localparam int AW    = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
    localparam int CLR_N = (MEM_WORDS > 16) ? MEM_WORDS : 16;
    localparam int CW    = $clog2(CLR_N + 1);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_REG, S_MEM, S_MUL, S_DIV
    } t_state;

    t_state      r_state, n_state;
    logic [CW-1:0] r_clr;
    t_in         r_in;
    logic [1:0]  r_cc, n_cc;
    logic        r_memform;
    logic        r_ok;
    logic [AW-1:0] r_n;
    logic [31:0] r_prod;
    t_out        r_res, n_res;
    logic        r_done, n_done;

    // storage
    logic [31:0] r_rf [0:15];
    logic [31:0] r_rf_a, r_rf_b;
    logic [32:0] r_mem [0:MEM_WORDS-1];
    logic [32:0] r_mem_q;

    logic        rf_we;
    logic [3:0]  rf_wa;
    logic [31:0] rf_wd;
    logic        mem_we;
    logic [AW-1:0] mem_wa;
    logic [32:0] mem_wd;
    logic        mem_re;
    logic [AW-1:0] mem_ra;

    logic        accept;
    logic [31:0] w_sum;
    logic        w_memform, w_ok;
    logic [AW-1:0] w_idx;
    logic [31:0] w_opb;
    logic [31:0] w_n32;
    logic        div_start, div_done;
    logic [31:0] div_q;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    // register file: written at result time, read at acceptance
    always_ff @(posedge i_clk) begin
        if (rf_we) begin
            r_rf[rf_wa] <= rf_wd;
        end
        if (accept) begin
            r_rf_a <= r_rf[i_cmd.dest_reg];
            r_rf_b <= r_rf[i_cmd.src_reg];
        end
    end

    // word memory: bit 32 holds the used mark
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_mem_q <= r_mem[mem_ra];
        end
    end

    // form the word address from base register plus displacement, or from the word index for preload and read
    always_comb begin
        w_sum     = r_rf_b + {16'd0, r_in.displacement};
        w_memform = (r_in.opcode == OP_ADDM) || (r_in.opcode == OP_SUBM) ||
                    (r_in.opcode == OP_MULM) || (r_in.opcode == OP_DIVM) ||
                    (r_in.opcode == OP_CMPM) || (r_in.opcode == OP_LD) ||
                    (r_in.opcode == OP_LEA) || (r_in.opcode == OP_ST);
        if (r_in.command == CMD_EXEC) begin
            // sums from -3 to -1 truncate toward word zero, -4 and below miss
            if (w_sum[31]) begin
                w_ok  = (&w_sum[31:2]) && (w_sum[1:0] != 2'd0);
                w_idx = '0;
            end else begin
                w_ok  = (w_sum[31:2] < 30'(MEM_WORDS));
                w_idx = AW'(w_sum[31:2]);
            end
        end else begin
            w_ok  = ({24'd0, r_in.word_index} < 32'(MEM_WORDS));
            w_idx = AW'(r_in.word_index);
        end
    end

    assign mem_re = (r_state == S_REG);
    assign mem_ra = w_idx;
    assign w_opb  = r_memform ? r_mem_q[31:0] : r_rf_b;
    assign w_n32  = 32'(r_n);

    assign div_start = (r_state == S_MEM) && (r_in.command == CMD_EXEC) &&
                       (!r_memform || r_ok) &&
                       ((r_in.opcode == OP_DIV) || (r_in.opcode == OP_DIVM)) &&
                       (w_opb != 32'd0);

    pae_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_a     (r_rf_a),
        .i_b     (w_opb),
        .o_done  (div_done),
        .o_q     (div_q)
    );

    // execute: build the result word and the write-backs
    always_comb begin
        logic [31:0] v;
        v       = '0;
        n_state = r_state;
        n_cc    = r_cc;
        n_res   = '0;
        n_done  = 1'b0;
        rf_we   = 1'b0;
        rf_wa   = r_in.dest_reg;
        rf_wd   = '0;
        mem_we  = 1'b0;
        mem_wa  = r_n;
        mem_wd  = '0;
        unique case (r_state)
            S_CLEAR: begin
                rf_we  = (r_clr < CW'(16));
                rf_wa  = r_clr[3:0];
                mem_we = (r_clr < CW'(MEM_WORDS));
                mem_wa = AW'(r_clr);
                if (r_clr == CW'(CLR_N - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = S_REG;
                end
            end
            S_REG: begin
                n_state = S_MEM;
            end
            S_MEM: begin
                n_done  = 1'b1;
                n_state = S_IDLE;
                if (r_in.command == CMD_PRELOAD || r_in.command == CMD_READ) begin
                    if (!r_ok) begin
                        n_res.status = ST_RANGE;
                    end else begin
                        n_res.mem_touched = 1'b1;
                        n_res.mem_index   = w_n32[7:0];
                        if (r_in.command == CMD_PRELOAD) begin
                            mem_we = 1'b1;
                            mem_wd = {r_in.word_used,
                                      r_in.word_used ? r_in.word_data : 32'sd0};
                        end else begin
                            n_res.read_data = r_mem_q[31:0];
                            n_res.read_used = r_mem_q[32];
                        end
                    end
                end else if (r_in.command == CMD_EXEC) begin
                    if (r_memform && !r_ok) begin
                        n_res.status = ST_RANGE;
                    end else begin
                        n_res.mem_touched = r_memform;
                        n_res.mem_index   = r_memform ? w_n32[7:0] : 8'd0;
                        unique case (r_in.opcode)
                            OP_ADD, OP_ADDM, OP_SUB, OP_SUBM, OP_MOV, OP_LD, OP_LEA: begin
                                if (r_in.opcode == OP_ADD || r_in.opcode == OP_ADDM) begin
                                    v = r_rf_a + w_opb;
                                end else if (r_in.opcode == OP_SUB ||
                                             r_in.opcode == OP_SUBM) begin
                                    v = r_rf_a - w_opb;
                                end else if (r_in.opcode == OP_LEA) begin
                                    v = {w_n32[29:0], 2'b00};
                                end else begin
                                    v = w_opb;
                                end
                                if (r_in.opcode == OP_ADD || r_in.opcode == OP_ADDM ||
                                    r_in.opcode == OP_SUB || r_in.opcode == OP_SUBM) begin
                                    n_cc = cond_of(v);
                                end
                                rf_we             = 1'b1;
                                rf_wd             = v;
                                n_res.reg_written = 1'b1;
                                n_res.reg_index   = r_in.dest_reg;
                                n_res.reg_value   = v;
                            end
                            OP_MUL, OP_MULM: begin
                                // hold the result until the product register fills
                                n_done  = 1'b0;
                                n_state = S_MUL;
                            end
                            OP_DIV, OP_DIVM: begin
                                if (w_opb == 32'd0) begin
                                    n_res.status = ST_DIV0;
                                end else begin
                                    n_done  = 1'b0;
                                    n_state = S_DIV;
                                end
                            end
                            OP_CMP, OP_CMPM: begin
                                n_cc            = cond_of(r_rf_a - w_opb);
                                n_res.reg_index = r_in.dest_reg;
                            end
                            OP_JMP, OP_JZ, OP_JP, OP_JN: begin
                                n_res.branch_target = r_in.displacement;
                                n_res.branch_taken  = (r_in.opcode == OP_JMP) ||
                                    (r_cc == (r_in.opcode[1:0] - 2'd1));
                            end
                            OP_ST: begin
                                mem_we          = 1'b1;
                                mem_wd          = {1'b1, r_rf_a};
                                n_res.reg_index = r_in.dest_reg;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
            S_MUL, S_DIV: begin
                v = (r_state == S_MUL) ? r_prod : div_q;
                if (r_state == S_MUL || div_done) begin
                    n_done            = 1'b1;
                    n_state           = S_IDLE;
                    n_cc              = cond_of(v);
                    rf_we             = 1'b1;
                    rf_wd             = v;
                    n_res.reg_written = 1'b1;
                    n_res.reg_index   = r_in.dest_reg;
                    n_res.reg_value   = v;
                    n_res.mem_touched = r_memform;
                    n_res.mem_index   = r_memform ? w_n32[7:0] : 8'd0;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_res.condition = n_cc;
    end

    // sequencer state and registered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_cc    <= CC_NONE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cc    <= n_cc;
            r_done  <= n_done;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_cmd;
        end
        if (r_state == S_REG) begin
            r_memform <= w_memform && (r_in.command == CMD_EXEC);
            r_ok      <= w_ok;
            r_n       <= w_idx;
        end
        if (r_state == S_MEM) begin
            r_prod <= r_rf_a * w_opb;
        end
        if (n_done) begin
            r_res <= n_res;
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

`ifndef SYNTHESIS
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_state == S_IDLE))
        else $error("result shown outside idle");
    a_range_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && o_res.status == ST_RANGE) |-> (!o_res.reg_written && !o_res.mem_touched))
        else $error("out of range word changed state");
    a_write_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && o_res.reg_written) |-> (o_res.status == ST_OK))
        else $error("register written with error status");
    a_accept_reg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_REG))
        else $error("accepted word did not start");
`endif
endmodule
`default_nettype wire

[rtl/pae_div.sv]
// Iterative signed 32-bit divider, one quotient bit per cycle.
`default_nettype none
module pae_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_a,
    input  wire logic [31:0] i_b,
    output logic             o_done,
    output logic [31:0]      o_q
);
    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [31:0] r_rem;
    logic [31:0] r_quo;
    logic [31:0] r_div;
    logic        r_neg;
    logic [32:0] w_sh;
    logic [32:0] w_diff;

    assign w_sh   = {r_rem, r_quo[31]};
    assign w_diff = w_sh - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_a[31] ? (32'd0 - i_a) : i_a;
                r_div  <= i_b[31] ? (32'd0 - i_b) : i_b;
                r_neg  <= i_a[31] ^ i_b[31];
            end else if (r_busy) begin
                // shift one dividend bit in, subtract where it fits
                if (!w_diff[32]) begin
                    r_rem <= w_diff[31:0];
                    r_quo <= {r_quo[30:0], 1'b1};
                end else begin
                    r_rem <= w_sh[31:0];
                    r_quo <= {r_quo[30:0], 1'b0};
                end
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_q    = r_neg ? (32'd0 - r_quo) : r_quo;
endmodule
`default_nettype wire
